// ----- hw/rtl/cvs_pkg.sv -----
// Shared types and constants of the closest value search block.
// Depends on nothing; used by cvs_table and closest_value_search.
`timescale 1ns / 1ps

package cvs_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int DATA_W      = 16;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int COUNT_W     = $clog2(TABLE_DEPTH + 1);
    localparam int IDX_W       = (ADDR_W + 1 > COUNT_W) ? ADDR_W + 1 : COUNT_W;

    // Command codes carried on the func field
    localparam logic [1:0] FUNC_CLEAR  = 2'd0;
    localparam logic [1:0] FUNC_APPEND = 2'd1;
    localparam logic [1:0] FUNC_QUERY  = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FIRST,
        S_LAST,
        S_MID,
        S_NBR_LO,
        S_NBR_HI,
        S_PICK
    } t_state;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] data;
    } t_wr_req;

endpackage

// ----- hw/rtl/closest_value_search.sv -----
// Top level of the closest value search block: sequencer and compare datapath.
// Depends on cvs_pkg and cvs_table.
`timescale 1ns / 1ps

// Usage
//   Input beat: i_func and i_value are taken at a rising edge where start is
//   high and busy is low. Clear (func 0) empties the table, append (func 1)
//   stores i_value behind the last entry (dropped when the table is full),
//   query (func 2) looks up the stored value nearest to i_value. Code 3 is
//   ignored. Clear and append leave busy low.
//   Result beat: only a query gives one. o_valid is high for exactly one
//   cycle with o_closest and o_table_empty; the receiver cannot stall, so
//   the beat is gone after that cycle.
//   Sequencing: a query on an empty table answers in the cycle after the
//   start beat. Otherwise busy is high while the sequencer probes the
//   table, one table read per cycle: the first entry, which ends the search
//   for a target at or below it, then the last entry, which ends it for one
//   at or above it, then a binary search with a neighbor read per probe and
//   a final nearer-of-two decision. The result beat comes in the cycle where
//   busy drops, and the next start is taken in that cycle. The single read
//   port of the table sets this rate.
//   Reset: synchronous, active low; the table is emptied (count zero), the
//   sequencer returns to idle and no result is pending. Table contents are
//   not cleared; only entries below the count are ever read.

module closest_value_search (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [1:0]                  i_func,
    input  logic [cvs_pkg::DATA_W-1:0]  i_value,
    output logic                        o_valid,
    output logic [cvs_pkg::DATA_W-1:0]  o_closest,
    output logic                        o_table_empty
);

    localparam int DW = cvs_pkg::DATA_W;
    localparam int AW = cvs_pkg::ADDR_W;
    localparam int CW = cvs_pkg::COUNT_W;
    localparam int IW = cvs_pkg::IDX_W;

    // Control state
    cvs_pkg::t_state r_state, n_state;
    logic [CW-1:0]   r_count, n_count;
    logic            r_valid, n_valid;

    // Search datapath
    logic [DW-1:0]   r_target, n_target;
    logic [IW-1:0]   r_lo, n_lo;
    logic [IW-1:0]   r_hi, n_hi;
    logic [IW-1:0]   r_mid, n_mid;
    logic [DW-1:0]   r_vmid, n_vmid;
    logic [DW-1:0]   r_pair_lo, n_pair_lo;
    logic [DW-1:0]   r_pair_hi, n_pair_hi;
    logic [DW-1:0]   r_closest, n_closest;
    logic            r_empty, n_empty;

    // Table ports
    cvs_pkg::t_wr_req w_wr;
    logic [AW-1:0]    w_rd_addr;
    logic [DW-1:0]    w_rd_data;

    cvs_table u_table (
        .i_clk     (i_clk),
        .i_wr      (w_wr),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    // Shared compare unit: target against the entry just read
    logic w_lt, w_eq, w_gt;
    assign w_lt = (r_target <  w_rd_data);
    assign w_eq = (r_target == w_rd_data);
    assign w_gt = !w_lt && !w_eq;

    // Extended count and neighbor checks
    logic [IW-1:0] w_count_x;
    logic [IW-1:0] w_mid_inc;
    logic          w_has_lo_nbr;
    logic          w_has_hi_nbr;
    assign w_count_x    = IW'(r_count);
    assign w_mid_inc    = r_mid + IW'(1);
    assign w_has_lo_nbr = (r_mid != '0);
    assign w_has_hi_nbr = (w_mid_inc < w_count_x);

    // Bounds after a probe that did not end the search, and the next midpoint
    logic          w_shrink_hi;
    logic [IW-1:0] w_step_lo;
    logic [IW-1:0] w_step_hi;
    logic [IW:0]   w_bound_sum;
    logic [IW-1:0] w_next_mid;
    logic          w_more;
    assign w_shrink_hi = ((r_state == cvs_pkg::S_MID) && w_lt) ||
                         (r_state == cvs_pkg::S_NBR_LO);
    assign w_step_lo   = w_shrink_hi ? r_lo : w_mid_inc;
    assign w_step_hi   = w_shrink_hi ? r_mid : r_hi;
    assign w_more      = (w_step_lo < w_step_hi);
    assign w_bound_sum = {1'b0, w_step_lo} + {1'b0, w_step_hi};
    assign w_next_mid  = w_bound_sum[IW:1];

    // Nearer of the bracketing pair: hi wins when 2*target >= lo + hi
    logic [DW:0] w_pair_sum;
    logic [DW:0] w_twice_target;
    logic        w_take_hi;
    assign w_pair_sum     = {1'b0, r_pair_lo} + {1'b0, r_pair_hi};
    assign w_twice_target = {r_target, 1'b0};
    assign w_take_hi      = (w_twice_target >= w_pair_sum);

    logic w_query_go;
    assign w_query_go = start && (i_func == cvs_pkg::FUNC_QUERY) && (r_count != '0);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            cvs_pkg::S_IDLE: begin
                if (w_query_go) n_state = cvs_pkg::S_FIRST;
            end
            cvs_pkg::S_FIRST: begin
                n_state = (w_lt || w_eq) ? cvs_pkg::S_IDLE : cvs_pkg::S_LAST;
            end
            cvs_pkg::S_LAST: begin
                n_state = (w_gt || w_eq) ? cvs_pkg::S_IDLE : cvs_pkg::S_MID;
            end
            cvs_pkg::S_MID: begin
                priority if (w_eq) begin
                    n_state = cvs_pkg::S_IDLE;
                end else if (w_lt && w_has_lo_nbr) begin
                    n_state = cvs_pkg::S_NBR_LO;
                end else if (w_gt && w_has_hi_nbr) begin
                    n_state = cvs_pkg::S_NBR_HI;
                end else begin
                    n_state = w_more ? cvs_pkg::S_MID : cvs_pkg::S_IDLE;
                end
            end
            cvs_pkg::S_NBR_LO: begin
                priority if (w_gt) n_state = cvs_pkg::S_PICK;
                else n_state = w_more ? cvs_pkg::S_MID : cvs_pkg::S_IDLE;
            end
            cvs_pkg::S_NBR_HI: begin
                priority if (w_lt) n_state = cvs_pkg::S_PICK;
                else n_state = w_more ? cvs_pkg::S_MID : cvs_pkg::S_IDLE;
            end
            cvs_pkg::S_PICK: begin
                n_state = cvs_pkg::S_IDLE;
            end
            default: begin
                n_state = cvs_pkg::S_IDLE;
            end
        endcase
    end

    // Datapath, table ports and result
    always_comb begin
        n_count   = r_count;
        n_valid   = 1'b0;
        n_target  = r_target;
        n_lo      = r_lo;
        n_hi      = r_hi;
        n_mid     = r_mid;
        n_vmid    = r_vmid;
        n_pair_lo = r_pair_lo;
        n_pair_hi = r_pair_hi;
        n_closest = r_closest;
        n_empty   = r_empty;
        w_wr.en   = 1'b0;
        w_wr.addr = r_count[AW-1:0];
        w_wr.data = i_value;
        w_rd_addr = '0;

        unique case (r_state)
            cvs_pkg::S_IDLE: begin
                // Present entry 0 so it is ready in the first probe cycle
                w_rd_addr = '0;
                n_target  = i_value;
                if (start) begin
                    unique case (i_func)
                        cvs_pkg::FUNC_CLEAR: begin
                            n_count = '0;
                        end
                        cvs_pkg::FUNC_APPEND: begin
                            // Drop the beat when the table is full
                            if (r_count < CW'(cvs_pkg::TABLE_DEPTH)) begin
                                w_wr.en = 1'b1;
                                n_count = r_count + CW'(1);
                            end
                        end
                        cvs_pkg::FUNC_QUERY: begin
                            if (r_count == '0) begin
                                n_valid   = 1'b1;
                                n_closest = '0;
                                n_empty   = 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            cvs_pkg::S_FIRST: begin
                w_rd_addr = AW'(w_count_x - IW'(1));
                if (w_lt || w_eq) begin
                    n_valid   = 1'b1;
                    n_closest = w_rd_data;
                    n_empty   = 1'b0;
                end
            end
            cvs_pkg::S_LAST: begin
                n_lo      = '0;
                n_hi      = w_count_x;
                n_mid     = w_count_x >> 1;
                w_rd_addr = AW'(w_count_x >> 1);
                if (w_gt || w_eq) begin
                    n_valid   = 1'b1;
                    n_closest = w_rd_data;
                    n_empty   = 1'b0;
                end
            end
            cvs_pkg::S_MID: begin
                n_vmid = w_rd_data;
                priority if (w_eq) begin
                    n_valid   = 1'b1;
                    n_closest = w_rd_data;
                    n_empty   = 1'b0;
                end else if (w_lt && w_has_lo_nbr) begin
                    w_rd_addr = AW'(r_mid - IW'(1));
                end else if (w_gt && w_has_hi_nbr) begin
                    w_rd_addr = AW'(w_mid_inc);
                end else begin
                    // Narrow the bounds and probe again, or end on this entry
                    n_lo      = w_step_lo;
                    n_hi      = w_step_hi;
                    n_mid     = w_next_mid;
                    w_rd_addr = AW'(w_next_mid);
                    if (!w_more) begin
                        n_valid   = 1'b1;
                        n_closest = w_rd_data;
                        n_empty   = 1'b0;
                    end
                end
            end
            cvs_pkg::S_NBR_LO, cvs_pkg::S_NBR_HI: begin
                if ((r_state == cvs_pkg::S_NBR_LO) ? w_gt : w_lt) begin
                    // Hold the bracketing pair for the distance decision
                    n_pair_lo = (r_state == cvs_pkg::S_NBR_LO) ? w_rd_data : r_vmid;
                    n_pair_hi = (r_state == cvs_pkg::S_NBR_LO) ? r_vmid : w_rd_data;
                end else begin
                    n_lo      = w_step_lo;
                    n_hi      = w_step_hi;
                    n_mid     = w_next_mid;
                    w_rd_addr = AW'(w_next_mid);
                    if (!w_more) begin
                        n_valid   = 1'b1;
                        n_closest = r_vmid;
                        n_empty   = 1'b0;
                    end
                end
            end
            cvs_pkg::S_PICK: begin
                n_valid   = 1'b1;
                n_closest = w_take_hi ? r_pair_hi : r_pair_lo;
                n_empty   = 1'b0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cvs_pkg::S_IDLE;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_target  <= n_target;
        r_lo      <= n_lo;
        r_hi      <= n_hi;
        r_mid     <= n_mid;
        r_vmid    <= n_vmid;
        r_pair_lo <= n_pair_lo;
        r_pair_hi <= n_pair_hi;
        r_closest <= n_closest;
        r_empty   <= n_empty;
    end

    assign busy          = (r_state != cvs_pkg::S_IDLE);
    assign o_valid       = r_valid;
    assign o_closest     = r_closest;
    assign o_table_empty = r_empty;

endmodule

// ----- hw/rtl/cvs_table.sv -----
// Value table of the closest value search: one write port, one registered read port.
// Depends on cvs_pkg.
`timescale 1ns / 1ps

module cvs_table (
    input  logic                         i_clk,
    input  cvs_pkg::t_wr_req             i_wr,
    input  logic [cvs_pkg::ADDR_W-1:0]   i_rd_addr,
    output logic [cvs_pkg::DATA_W-1:0]   o_rd_data
);

    logic [cvs_pkg::DATA_W-1:0] r_mem [cvs_pkg::TABLE_DEPTH];
    logic [cvs_pkg::DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    // Register the read data; it shows in the cycle after the address
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule
